// ===== sv/tbc_pkg.sv =====
// Shared types and constants for the thermistor beta-equation converter.
// Used by the channel interfaces, the pipeline cells and the top level.
package tbc_pkg;

	localparam int ADC_BITS = 10;
	localparam int FS = (1 << ADC_BITS) - 1;
	localparam int NUM_W = ADC_BITS + 3;
	localparam int DEN_W = ADC_BITS + 4;

	localparam int TEMP_W = 16;
	localparam int SUPPLY_W = 3;
	localparam int BETA_W = 16;
	localparam int FIXED_W = 20;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int LOG_FRAC = 24;
	localparam int MSB_W = 5;
	localparam int M_W = 32;
	localparam int LOG_W = MSB_W + LOG_FRAC;

	// beta*2^24*100/29815 = beta*C_INT + beta*C_REM/29815
	localparam int C_W = 32;
	localparam int Y_W = 27;
	localparam int PE_W = 55;
	localparam int RECIP_SH = 42;
	localparam int QE_W = PE_W - RECIP_SH;
	localparam logic [C_W-1:0] C_INT = 32'd56271;
	localparam logic [Y_W-1:0] C_REM = 27'd1735;
	localparam logic [PE_W-1:0] C_RECIP = 55'd147511202;
	localparam logic [Y_W-1:0] T_REF = 27'd29815;

	localparam int PROD_W = 61;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam int LN_SH = 30;
	localparam int SC_W = 47;
	localparam logic [SC_W-1:0] SCALE = 47'd1677721600;
	localparam int D_W = 34;
	localparam int N_W = 50;
	localparam int Q_W = 16;

	localparam logic [Q_W-1:0] TK_MAX = 16'd60082;
	localparam logic [Q_W:0] T_OFS = 17'd27315;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd27315;

	localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 3'd5;
	localparam logic [BETA_W-1:0] BETA_RST = 16'd3950;
	localparam logic [FIXED_W-1:0] FIXED_RST = 20'd10000;

	typedef enum logic [1:0] {
		REG_SUPPLY = 2'd0,
		REG_BETA = 2'd1,
		REG_FIXED = 2'd2
	} reg_idx_t;

	// one token of the log2 chain: both operands squared side by side
	typedef struct packed {
		logic inv;
		logic [BETA_W-1:0] beta;
		logic [C_W-1:0] c;
		logic [MSB_W-1:0] p_num;
		logic [MSB_W-1:0] p_den;
		logic [M_W-1:0] m_num;
		logic [M_W-1:0] m_den;
		logic [LOG_FRAC-1:0] f_num;
		logic [LOG_FRAC-1:0] f_den;
	} log_tok_t;

	// one token of the restoring divider chain
	typedef struct packed {
		logic inv;
		logic bzero;
		logic hot;
		logic ovf;
		logic [N_W-1:0] rem;
		logic [N_W-1:0] dsh;
		logic [Q_W-1:0] q;
	} div_tok_t;

	function automatic logic [MSB_W-1:0] msb_pos(input logic [NUM_W-1:0] x);
		logic [MSB_W-1:0] p;
		p = '0;
		for (int i = 0; i < NUM_W; i++) begin
			if (x[i]) begin
				p = MSB_W'(i);
			end
		end
		return p;
	endfunction

endpackage

// ===== sv/tbc_if.sv =====
// Valid/ready channels of the converter: ADC sample in, temperature out.
// Depends on tbc_pkg for the field widths.
interface tbc_in_if import tbc_pkg::*; ();
	logic valid;
	logic ready;
	logic [ADC_BITS-1:0] adc_code;
	modport source(output valid, output adc_code, input ready);
	modport sink(input valid, input adc_code, output ready);
endinterface

interface tbc_out_if import tbc_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [TEMP_W-1:0] temp_centi_c;
	logic valid_res;
	modport source(output valid, output temp_centi_c, output valid_res, input ready);
	modport sink(input valid, input temp_centi_c, input valid_res, output ready);
endinterface

// ===== sv/tbc_log_cell.sv =====
// One fraction bit of log2 for both operands: square the mantissa, renormalise.
// Depends on tbc_pkg for the token type.
module tbc_log_cell import tbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input log_tok_t tok_i,
	output logic vld_o,
	output log_tok_t tok_o
);

	logic vld_s1;
	log_tok_t tok_s1;
	log_tok_t tok_n;
	logic [2*M_W-1:0] sq_num;
	logic [2*M_W-1:0] sq_den;
	logic [M_W:0] t_num;
	logic [M_W:0] t_den;

	always_comb begin
		sq_num = (2*M_W)'(tok_i.m_num) * (2*M_W)'(tok_i.m_num);
		sq_den = (2*M_W)'(tok_i.m_den) * (2*M_W)'(tok_i.m_den);
		t_num = sq_num[2*M_W-1:M_W-1];
		t_den = sq_den[2*M_W-1:M_W-1];
		tok_n = tok_i;
		tok_n.f_num = {tok_i.f_num[LOG_FRAC-2:0], t_num[M_W]};
		tok_n.f_den = {tok_i.f_den[LOG_FRAC-2:0], t_den[M_W]};
		// halve when the square reached two
		tok_n.m_num = t_num[M_W] ? t_num[M_W:1] : t_num[M_W-1:0];
		tok_n.m_den = t_den[M_W] ? t_den[M_W:1] : t_den[M_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1 <= tok_n;
		end
	end

	assign vld_o = vld_s1;
	assign tok_o = tok_s1;

endmodule

// ===== sv/tbc_div_cell.sv =====
// One quotient bit of the restoring divide for the kelvin result.
// Depends on tbc_pkg for the token type.
module tbc_div_cell import tbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input div_tok_t tok_i,
	output logic vld_o,
	output div_tok_t tok_o
);

	logic vld_s1;
	div_tok_t tok_s1;
	div_tok_t tok_n;

	always_comb begin
		tok_n = tok_i;
		if (tok_i.rem >= tok_i.dsh) begin
			tok_n.rem = tok_i.rem - tok_i.dsh;
			tok_n.q = {tok_i.q[Q_W-2:0], 1'b1};
		end else begin
			tok_n.q = {tok_i.q[Q_W-2:0], 1'b0};
		end
		tok_n.dsh = tok_i.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1 <= tok_n;
		end
	end

	assign vld_o = vld_s1;
	assign tok_o = tok_s1;

endmodule

// ===== sv/thermistor_beta_to_celsius_top.sv =====
// NTC thermistor converter: ADC code to temperature in hundredths of a degree C.
// Depends on tbc_pkg, tbc_if, tbc_log_cell and tbc_div_cell.
//
// Usage:
// - sample (valid/ready) carries one adc_code per request; result (valid/ready)
//   returns temp_centi_c and valid_res, one result per sample, in order.
// - Registers on the APB port: supply_volts at 0x0, beta_coefficient at 0x4,
//   fixed_resistor_ohms at 0x8. Write them only while no sample is in flight.
// - From the accepting edge to result valid a sample passes through 47
//   register stages: six front and back stages, a chain of 24 squaring cells
//   for the log2 fraction bits, a chain of 16 restoring-divide cells for the
//   quotient and the output register.
// - Throughput is one sample per cycle while the pipeline is not held; the cell chains are fully pipelined.
// - A result waits in the output register until taken. While it waits the
//   pipeline keeps moving as long as a bubble sits in front of it, so samples
//   are still taken; once the last stage holds a result too, everything holds
//   and sample.ready drops.
// - Reset clears all stage valids and loads the register defaults
//   (5 V, beta 3950, 10 kohm); samples in flight are lost, none is invented.
module thermistor_beta_to_celsius_top import tbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	tbc_in_if.sink sample,
	tbc_out_if.source result
);

	// configuration
	logic [SUPPLY_W-1:0] supply_q;
	logic [BETA_W-1:0] beta_q;
	logic [FIXED_W-1:0] fixed_q;
	reg_idx_t reg_idx;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= SUPPLY_RST;
			beta_q <= BETA_RST;
			fixed_q <= FIXED_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_SUPPLY: supply_q <= pwdata[SUPPLY_W-1:0];
				REG_BETA: beta_q <= pwdata[BETA_W-1:0];
				REG_FIXED: fixed_q <= pwdata[FIXED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SUPPLY: prdata = DATA_W'(supply_q);
			REG_BETA: prdata = DATA_W'(beta_q);
			REG_FIXED: prdata = DATA_W'(fixed_q);
			default: prdata = '0;
		endcase
	end

	// flow control
	logic en;
	logic out_vld_q;
	logic last_vld;
	div_tok_t last_tok;

	assign en = !out_vld_q || result.ready || !last_vld;
	assign sample.ready = en;

	// stage 1: divider voltages and the beta-only products
	logic [NUM_W-1:0] num_c;
	logic signed [DEN_W-1:0] den_c;
	logic inv_c;
	logic v_s1, inv_s1;
	logic [NUM_W-1:0] num_s1, den_s1;
	logic [BETA_W-1:0] beta_s1;
	logic [Y_W-1:0] y_s1;
	logic [C_W-1:0] c1_s1;

	always_comb begin
		num_c = (NUM_W'(sample.adc_code) << 2) + NUM_W'(sample.adc_code);
		den_c = $signed(DEN_W'(supply_q) * DEN_W'(FS)) - $signed(DEN_W'(num_c));
		inv_c = (sample.adc_code == '0) || (den_c <= 0);
	end

	// stage 2: normalise both operands, estimate the remainder quotient
	logic [PE_W-1:0] pe_c;
	logic v_s2, inv_s2;
	logic [MSB_W-1:0] p_num_s2, p_den_s2;
	logic [M_W-1:0] m_num_s2, m_den_s2;
	logic [BETA_W-1:0] beta_s2;
	logic [Y_W-1:0] y_s2;
	logic [QE_W-1:0] qe_s2;
	logic [C_W-1:0] c1_s2;
	logic [MSB_W-1:0] p_num_c, p_den_c;

	always_comb begin
		pe_c = PE_W'(y_s1) * C_RECIP;
		p_num_c = msb_pos(num_s1);
		p_den_c = msb_pos(den_s1);
	end

	// stage 3: correct the quotient and form beta/298.15 in Q.24
	logic [Y_W-1:0] r_c;
	logic [QE_W-1:0] qc_c;
	logic v_s3;
	log_tok_t tok_s3;
	log_tok_t tok3_c;

	always_comb begin
		r_c = y_s2 - Y_W'(qe_s2) * T_REF;
		qc_c = (r_c >= T_REF) ? qe_s2 + QE_W'(1) : qe_s2;
		tok3_c.inv = inv_s2;
		tok3_c.beta = beta_s2;
		tok3_c.c = c1_s2 + C_W'(qc_c);
		tok3_c.p_num = p_num_s2;
		tok3_c.p_den = p_den_s2;
		tok3_c.m_num = m_num_s2;
		tok3_c.m_den = m_den_s2;
		tok3_c.f_num = '0;
		tok3_c.f_den = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= inv_c;
			num_s1 <= num_c;
			den_s1 <= NUM_W'(den_c);
			beta_s1 <= beta_q;
			y_s1 <= Y_W'(beta_q) * C_REM;
			c1_s1 <= C_W'(beta_q) * C_INT;

			inv_s2 <= inv_s1;
			p_num_s2 <= p_num_c;
			p_den_s2 <= p_den_c;
			m_num_s2 <= M_W'(num_s1) << (MSB_W'(M_W - 1) - p_num_c);
			m_den_s2 <= M_W'(den_s1) << (MSB_W'(M_W - 1) - p_den_c);
			beta_s2 <= beta_s1;
			y_s2 <= y_s1;
			qe_s2 <= pe_c[PE_W-1:RECIP_SH];
			c1_s2 <= c1_s1;

			tok_s3 <= tok3_c;
		end
	end

	// log2 chain
	logic log_v [0:LOG_FRAC];
	log_tok_t log_tok [0:LOG_FRAC];

	assign log_v[0] = v_s3;
	assign log_tok[0] = tok_s3;

	for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
		tbc_log_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(log_v[g]),
			.tok_i(log_tok[g]),
			.vld_o(log_v[g+1]),
			.tok_o(log_tok[g+1])
		);
	end

	// stage 4: log difference times ln 2
	log_tok_t lt;
	logic signed [LOG_W:0] d_c;
	logic signed [PROD_W-1:0] prod_c;
	logic v_s4, inv_s4, bzero_s4;
	logic signed [PROD_W-1:0] prod_s4;
	logic [SC_W-1:0] scaled_s4;
	logic [C_W-1:0] c_s4;

	always_comb begin
		lt = log_tok[LOG_FRAC];
		d_c = $signed({1'b0, lt.p_num, lt.f_num}) - $signed({1'b0, lt.p_den, lt.f_den});
		prod_c = PROD_W'(d_c) * PROD_W'($signed({1'b0, LN2_Q30}));
	end

	// stage 5: truncate toward zero, add beta/298.15
	logic signed [PROD_W-1:0] adj_c;
	logic signed [PROD_W-1:0] ln_c;
	logic v_s5, inv_s5, bzero_s5;
	logic signed [D_W-1:0] dq_s5;
	logic [SC_W-1:0] scaled_s5;

	always_comb begin
		adj_c = prod_s4 + ((prod_s4 < 0) ? PROD_W'((64'd1 << LN_SH) - 64'd1) : '0);
		ln_c = adj_c >>> LN_SH;
	end

	// stage 6: numerator and overflow test ahead of the divide
	logic [N_W-1:0] n_c;
	logic [N_W-1:0] dpos_c;
	div_tok_t tok6_c;
	logic v_s6;
	div_tok_t tok_s6;

	always_comb begin
		n_c = (N_W'(scaled_s5) << 1) + N_W'(dq_s5);
		dpos_c = N_W'(dq_s5[D_W-2:0]);
		tok6_c.inv = inv_s5;
		tok6_c.bzero = bzero_s5;
		tok6_c.hot = (dq_s5 <= 0);
		tok6_c.ovf = (n_c >= (dpos_c << (Q_W + 1)));
		tok6_c.rem = n_c;
		tok6_c.dsh = dpos_c << Q_W;
		tok6_c.q = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= log_v[LOG_FRAC];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s4 <= lt.inv;
			bzero_s4 <= (lt.beta == '0);
			prod_s4 <= prod_c;
			scaled_s4 <= SC_W'(lt.beta) * SCALE;
			c_s4 <= lt.c;

			inv_s5 <= inv_s4;
			bzero_s5 <= bzero_s4;
			dq_s5 <= D_W'(ln_c) + $signed(D_W'(c_s4));
			scaled_s5 <= scaled_s4;

			tok_s6 <= tok6_c;
		end
	end

	// divide chain
	logic div_v [0:Q_W];
	div_tok_t div_tok [0:Q_W];

	assign div_v[0] = v_s6;
	assign div_tok[0] = tok_s6;

	for (genvar g = 0; g < Q_W; g++) begin : g_div
		tbc_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(div_v[g]),
			.tok_i(div_tok[g]),
			.vld_o(div_v[g+1]),
			.tok_o(div_tok[g+1])
		);
	end

	assign last_vld = div_v[Q_W];
	assign last_tok = div_tok[Q_W];

	// output register
	logic signed [TEMP_W-1:0] temp_c;
	logic vres_c;
	logic signed [TEMP_W-1:0] temp_q;
	logic vres_q;

	always_comb begin
		vres_c = 1'b1;
		if (last_tok.inv) begin
			temp_c = '0;
			vres_c = 1'b0;
		end else if (last_tok.bzero) begin
			temp_c = TEMP_MIN;
		end else if (last_tok.hot || last_tok.ovf || (last_tok.q > TK_MAX)) begin
			temp_c = TEMP_MAX;
		end else begin
			temp_c = $signed(TEMP_W'({1'b0, last_tok.q} - T_OFS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || result.ready) begin
			out_vld_q <= last_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || result.ready) begin
			temp_q <= temp_c;
			vres_q <= vres_c;
		end
	end

	assign result.valid = out_vld_q;
	assign result.temp_centi_c = temp_q;
	assign result.valid_res = vres_q;

endmodule

// ===== test/thermistor_beta_to_celsius_top_test.sv =====
// Testbench for the thermistor beta-equation converter: directed and random ADC
// codes under several register settings, checked against an in-bench predictor.
// Depends on tbc_pkg, tbc_if and thermistor_beta_to_celsius_top.
`timescale 1ns / 100ps

module thermistor_beta_to_celsius_top_test;
	import tbc_pkg::*;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic ok;
	} temp_exp_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	tbc_in_if sample();
	tbc_out_if result();

	thermistor_beta_to_celsius_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample(sample.source), .result(result.sink)
	);

	logic [SUPPLY_W-1:0] cur_supply;
	logic [BETA_W-1:0] cur_beta;
	logic [FIXED_W-1:0] cur_fixed;
	temp_exp_t temp_queue[$];
	int mismatches;
	int sink_idle_pct;
	int sink_hold;
	int src_idle_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("thermistor_beta_to_celsius_top verification failed");
		$finish;
	end

	// log2 in Q.24, fraction by repeated squaring of the Q1.31 mantissa
	function automatic longint log2_fix(longint unsigned x);
		int p;
		longint unsigned m;
		longint r;
		p = 0;
		while (p < 31 && (x >> (p + 1)) != 0) p++;
		m = x << (31 - p);
		r = longint'(p) << LOG_FRAC;
		for (int i = 1; i <= LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				r += longint'(1) << (LOG_FRAC - i);
				m >>= 1;
			end
		end
		return r;
	endfunction

	function automatic temp_exp_t predict_temp(logic [ADC_BITS-1:0] code);
		temp_exp_t e;
		longint num, den, bt, d, l, sc, c, dq, t;
		num = 5 * longint'(code);
		den = longint'(cur_supply) * FS - num;
		bt = longint'(cur_beta);
		e.ok = 1'b1;
		if (code == 0 || den <= 0) begin
			t = 0;
			e.ok = 1'b0;
		end else if (bt == 0) begin
			t = -27315;
		end else begin
			d = log2_fix(num) - log2_fix(den);
			l = d * 744261118 / (longint'(1) << 30);
			sc = bt * (longint'(1) << LOG_FRAC) * 100;
			c = sc / 29815;
			dq = l + c;
			if (dq <= 0) begin
				t = 32767;
			end else begin
				t = (2 * sc + dq) / (2 * dq) - 27315;
				if (t > 32767) t = 32767;
				if (t < -27315) t = -27315;
			end
		end
		e.temp = TEMP_W'(t);
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("%t mismatch %s: got %0d want %0d", $realtime, what, got, want);
	endtask

	// result sink: random stall, plus a long hold-off when sink_hold is set
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (temp_queue.size() == 0) begin
					report_mismatch("unexpected result", result.temp_centi_c, 0);
				end else begin
					temp_exp_t e;
					e = temp_queue.pop_front();
					if (result.temp_centi_c !== e.temp)
						report_mismatch("temp_centi_c", result.temp_centi_c, e.temp);
					if (result.valid_res !== e.ok)
						report_mismatch("valid_res", result.valid_res, e.ok);
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SUPPLY: cur_supply = val[SUPPLY_W-1:0];
			REG_BETA: cur_beta = val[BETA_W-1:0];
			REG_FIXED: cur_fixed = val[FIXED_W-1:0];
			default: ;
		endcase
	endtask

	// send one sample; valid stays high back to back when no idle is drawn
	task automatic send_code(logic [ADC_BITS-1:0] code);
		while ($urandom_range(99) < src_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.adc_code <= code;
		temp_queue.push_back(predict_temp(code));
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
	endtask

	task automatic drain;
		sample.valid <= 1'b0;
		while (temp_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_regs(logic [2:0] sv, logic [15:0] bt, logic [19:0] fx);
		apb_write(REG_SUPPLY, sv);
		apb_write(REG_BETA, bt);
		apb_write(REG_FIXED, fx);
	endtask

	function automatic logic [ADC_BITS-1:0] rand_code();
		int k;
		k = $urandom_range(9);
		if (k == 0) return ADC_BITS'($urandom_range(3));
		if (k == 1) return ADC_BITS'(FS - $urandom_range(3));
		return ADC_BITS'($urandom);
	endfunction

	task automatic test_directed;
		logic [ADC_BITS-1:0] codes[$] = '{0, 1, 2, 511, 512, 1023, 1022, 341, 342, 700};
		foreach (codes[i]) send_code(codes[i]);
		drain();
		// zero beta gives absolute zero; low supply pushes codes to invalid
		set_regs(3'd1, 16'd0, 20'd1);
		foreach (codes[i]) send_code(codes[i]);
		drain();
		set_regs(3'd0, 16'd65535, 20'd1000000);
		send_code(10'd5);
		send_code(10'd1023);
		drain();
		set_regs(3'd7, 16'd1, 20'hFFFFF);
		send_code(10'd1);
		send_code(10'd1023);
		send_code(10'd600);
		drain();
	endtask

	task automatic test_random_settings;
		for (int ph = 0; ph < 8; ph++) begin
			set_regs(3'($urandom_range(7)),
				(ph % 3 == 0) ? 16'($urandom_range(1, 20)) : 16'($urandom),
				20'($urandom));
			src_idle_pct = (ph == 3) ? 0 : 37;
			sink_idle_pct = (ph == 3) ? 0 : 37;
			repeat (180) send_code(rand_code());
			drain();
		end
		src_idle_pct = 37;
		sink_idle_pct = 37;
	endtask

	task automatic test_backpressure;
		set_regs(3'd5, 16'd3950, 20'd10000);
		sink_hold = 150;
		src_idle_pct = 0;
		repeat (200) send_code(rand_code());
		src_idle_pct = 37;
		drain();
	endtask

	initial begin
		mismatches = 0;
		sink_hold = 0;
		sink_idle_pct = 37;
		src_idle_pct = 37;
		cur_supply = SUPPLY_RST;
		cur_beta = BETA_RST;
		cur_fixed = FIXED_RST;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample.valid <= 1'b0;
		sample.adc_code <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		if (mismatches == 0) begin
			$display("thermistor_beta_to_celsius_top verification clean");
		end else begin
			$display("thermistor_beta_to_celsius_top verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tbc_pkg.sv
sv/tbc_if.sv
sv/tbc_log_cell.sv
sv/tbc_div_cell.sv
sv/thermistor_beta_to_celsius_top.sv
test/thermistor_beta_to_celsius_top_test.sv
